@@ sv/hsch_pkg.sv @@
package hsch_pkg;

  localparam int NumBinsDef     = 400;
  localparam int NumSeptantsDef = 7;
  localparam int CordicStepsDef = 16;

  localparam int StepW   = 5;   // holds up to 24 steps
  localparam int BinW    = 10;  // radius / 80 stays below 820
  localparam int SumW    = 64;
  localparam int CordW   = 34;  // scaled position plus CORDIC growth
  localparam int InDataW = 144;
  localparam int OutDataW = 264;

  localparam logic [15:0] DetResetVal = 16'd28;

  typedef enum logic [2:0] {
    REG_DET_SEL      = 3'd0,
    REG_OPEN_R_MIN   = 3'd1,
    REG_OPEN_R_MAX   = 3'd2,
    REG_TRANS_R_MIN  = 3'd3,
    REG_TRANS_R_MAX  = 3'd4,
    REG_CLOSED_R_MIN = 3'd5,
    REG_CLOSED_R_MAX = 3'd6,
    REG_UNUSED       = 3'd7
  } reg_idx_e;

  typedef enum logic [1:0] {
    CLS_CLOSED = 2'd0,
    CLS_TRANS  = 2'd1,
    CLS_OPEN   = 2'd2,
    CLS_NONE   = 2'd3
  } sector_cls_e;

  typedef enum logic [2:0] {
    ST_IDLE, ST_CORDIC, ST_EVAL, ST_HIST, ST_RESULT
  } top_state_e;

  typedef enum logic [2:0] {
    HS_CLEAR, HS_IDLE, HS_RD, HS_CAP
  } hist_state_e;

  typedef struct packed {
    logic            start;
    logic            rd;
    logic [1:0]      cls;
    logic [BinW-1:0] bin;
    logic [31:0]     weight;
  } hist_req_t;

  typedef struct packed {
    logic            ready;
    logic            done;
    logic [SumW-1:0] sum_all;
    logic [SumW-1:0] sum_closed;
    logic [SumW-1:0] sum_trans;
    logic [SumW-1:0] sum_open;
  } hist_rsp_t;

  function automatic logic [31:0] atan_turns(input logic [StepW-1:0] idx);
    logic [31:0] v;
    unique case (idx)
      5'd0:  v = 32'h20000000;
      5'd1:  v = 32'h12E4051E;
      5'd2:  v = 32'h09FB385B;
      5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;
      5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;
      5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;
      5'd9:  v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2FA;
      5'd15: v = 32'h0000517D;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A30;
      5'd19: v = 32'h00000518;
      5'd20: v = 32'h0000028C;
      5'd21: v = 32'h00000146;
      5'd22: v = 32'h000000A3;
      5'd23: v = 32'h00000051;
      default: v = 32'h0;
    endcase
    return v;
  endfunction

endpackage

@@ sv/hit_sector_cut_histogrammer.sv @@
// Channel   Dir  Contents
// s_axis    in   tuser: opcode; tdata: pos_x, pos_y, radius, detector_id, particle_code,
//                hit_weight, bin_select (low bit first), zero filled to 144 bits
// m_axis    out  tdata: sector_class, accepted, sum_all, sum_closed, sum_trans, sum_open
// cfg       in   cfg_we_i, cfg_idx_i, cfg_data_i; write only
//
// A hit's time is set mostly by the CORDIC loop, one micro-rotation per cycle;
// a rejected hit skips the histogram update.
// A bin read makes three passes over the single-port class memory.
// After reset the histograms are cleared with tready low.
// A finished result waits in the output register while the next request is worked on;
// a new result is held back until the previous one has left or is leaving.
module hit_sector_cut_histogrammer #(
  parameter int NUM_BINS     = hsch_pkg::NumBinsDef,
  parameter int NUM_SEPTANTS = hsch_pkg::NumSeptantsDef,
  parameter int CORDIC_STEPS = hsch_pkg::CordicStepsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // pos_x, pos_y, radius, detector_id, particle_code, hit_weight, bin_select
  input  logic [hsch_pkg::InDataW-1:0]  s_axis_tdata,
  // opcode
  input  logic                          s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // sector_class, accepted, sum_all, sum_closed, sum_trans, sum_open
  output logic [hsch_pkg::OutDataW-1:0] m_axis_tdata,
  input  logic                          cfg_we_i,
  input  logic [2:0]                    cfg_idx_i,
  input  logic [15:0]                   cfg_data_i
);

  hsch_pkg::top_state_e state_q, state_d;
  hsch_pkg::hist_req_t  hreq;
  hsch_pkg::hist_rsp_t  hrsp;

  logic [15:0] det_sel_q, o_min_q, o_max_q, t_min_q, t_max_q, c_min_q, c_max_q;
  logic        op_q;
  logic [16:0] px_q, py_q;
  logic [15:0] rad_q, det_q;
  logic [31:0] pid_q, w_q;
  logic [1:0]  cls_q, cls_d;
  logic        ok_q, ok_d;
  logic [hsch_pkg::BinW-1:0] bin_q, bin_d;
  logic        ovalid_q, ovalid_d;
  logic [hsch_pkg::OutDataW-1:0] odata_q, odata_d;
  logic        cstart, cdone, accept, origin, pid_ok, out_free;
  logic [31:0] angle;
  logic [34:0] ang7;
  logic [2:0]  slice;
  logic [15:0] lo, hi;
  logic [23:0] quot;

  assign accept   = s_axis_tvalid && s_axis_tready;
  assign out_free = !ovalid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      det_sel_q <= hsch_pkg::DetResetVal;
      o_min_q <= '0; o_max_q <= '1;
      t_min_q <= '0; t_max_q <= '1;
      c_min_q <= '0; c_max_q <= '1;
    end else if (cfg_we_i) begin
      unique case (hsch_pkg::reg_idx_e'(cfg_idx_i))
        hsch_pkg::REG_DET_SEL:      det_sel_q <= cfg_data_i;
        hsch_pkg::REG_OPEN_R_MIN:   o_min_q   <= cfg_data_i;
        hsch_pkg::REG_OPEN_R_MAX:   o_max_q   <= cfg_data_i;
        hsch_pkg::REG_TRANS_R_MIN:  t_min_q   <= cfg_data_i;
        hsch_pkg::REG_TRANS_R_MAX:  t_max_q   <= cfg_data_i;
        hsch_pkg::REG_CLOSED_R_MIN: c_min_q   <= cfg_data_i;
        hsch_pkg::REG_CLOSED_R_MAX: c_max_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= s_axis_tuser;
      px_q   <= s_axis_tdata[16:0];
      py_q   <= s_axis_tdata[33:17];
      rad_q  <= s_axis_tdata[49:34];
      det_q  <= s_axis_tdata[65:50];
      pid_q  <= s_axis_tdata[97:66];
      w_q    <= s_axis_tdata[129:98];
    end
  end

  // the CORDIC loads its start vector at the accepting edge, straight from the bus
  hsch_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cstart),
    .pos_x_i (s_axis_tdata[16:0]),
    .pos_y_i (s_axis_tdata[33:17]),
    .done_o  (cdone),
    .angle_o (angle)
  );

  hsch_hist #(.NUM_BINS(NUM_BINS)) u_hist (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (hreq),
    .rsp_o  (hrsp)
  );

  always_comb begin
    // fold into a septant: slice within it is bits 31:29 of angle * septants
    ang7   = 35'(angle) * 35'(NUM_SEPTANTS);
    slice  = ang7[31:29];
    origin = (px_q == '0) && (py_q == '0);
    pid_ok = (pid_q == 32'd11)  || (pid_q == -32'sd11)  ||
             (pid_q == 32'd211) || (pid_q == -32'sd211) ||
             (pid_q == 32'd13)  || (pid_q == -32'sd13);
    if (origin) cls_d = hsch_pkg::CLS_CLOSED;
    else begin
      case (slice)
        3'd0, 3'd7: cls_d = hsch_pkg::CLS_CLOSED;
        3'd3, 3'd4: cls_d = hsch_pkg::CLS_OPEN;
        default:    cls_d = hsch_pkg::CLS_TRANS;
      endcase
    end
    case (cls_d)
      hsch_pkg::CLS_CLOSED: begin lo = c_min_q; hi = c_max_q; end
      hsch_pkg::CLS_TRANS:  begin lo = t_min_q; hi = t_max_q; end
      default:              begin lo = o_min_q; hi = o_max_q; end
    endcase
    // radius / 80 as (radius / 16) / 5 by reciprocal
    quot  = 24'(rad_q[15:4]) * 24'd3277;
    bin_d = quot[23:14];
    ok_d  = !origin && (det_q == det_sel_q) && pid_ok && (rad_q >= lo) && (rad_q < hi) &&
            (13'(bin_d) < 13'(NUM_BINS));
  end

  always_comb begin
    state_d  = state_q;
    cstart   = 1'b0;
    hreq     = '0;
    ovalid_d = ovalid_q && !m_axis_tready;
    odata_d  = odata_q;
    s_axis_tready = (state_q == hsch_pkg::ST_IDLE) && hrsp.ready;
    unique case (state_q)
      hsch_pkg::ST_IDLE: begin
        if (accept) state_d = s_axis_tuser ? hsch_pkg::ST_HIST : hsch_pkg::ST_CORDIC;
        hreq.start = accept && s_axis_tuser;
        hreq.rd    = 1'b1;
        hreq.bin   = hsch_pkg::BinW'(s_axis_tdata[138:130]);
        cstart     = accept && !s_axis_tuser;
      end
      hsch_pkg::ST_CORDIC: if (cdone) state_d = hsch_pkg::ST_EVAL;
      hsch_pkg::ST_EVAL: begin
        hreq.start  = ok_q;
        hreq.rd     = 1'b0;
        hreq.cls    = cls_q;
        hreq.bin    = bin_q;
        hreq.weight = w_q;
        state_d     = ok_q ? hsch_pkg::ST_HIST : hsch_pkg::ST_RESULT;
      end
      hsch_pkg::ST_HIST: if (hrsp.done) state_d = hsch_pkg::ST_RESULT;
      hsch_pkg::ST_RESULT: begin
        if (out_free) begin
          ovalid_d = 1'b1;
          if (op_q) odata_d = {5'b0, hrsp.sum_open, hrsp.sum_trans, hrsp.sum_closed,
                               hrsp.sum_all, 3'b0};
          else      odata_d = {5'b0, 256'b0, ok_q, cls_q};
          state_d = hsch_pkg::ST_IDLE;
        end
      end
      default: state_d = hsch_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cdone) begin
      cls_q <= cls_d;
      ok_q  <= ok_d;
      bin_q <= bin_d;
    end
    odata_q <= odata_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= hsch_pkg::ST_IDLE;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
    end
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = odata_q;

  a_cordic_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cdone |-> state_q == hsch_pkg::ST_CORDIC) else $error("cordic done out of turn");
  a_hist_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hrsp.done |-> state_q == hsch_pkg::ST_HIST) else $error("histogram done out of turn");
  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !hrsp.ready |-> !s_axis_tready) else $error("request taken while memory busy");
  a_class_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[1:0] != hsch_pkg::CLS_NONE) else $error("bad class");

endmodule

@@ sv/hsch_cordic.sv @@
module hsch_cordic #(
  parameter int CORDIC_STEPS = hsch_pkg::CordicStepsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [16:0] pos_x_i,
  input  logic [16:0] pos_y_i,
  output logic        done_o,
  output logic [31:0] angle_o
);

  localparam int W = hsch_pkg::CordW;

  logic                      busy_q, busy_d, done_q, done_d;
  logic signed [W-1:0]       x_q, x_d, y_q, y_d, xs, ys, dx, dy;
  logic [31:0]               z_q, z_d;
  logic [hsch_pkg::StepW-1:0] i_q, i_d;

  always_comb begin
    xs = $signed({{5{pos_x_i[16]}}, pos_x_i, 12'b0});
    ys = $signed({{5{pos_y_i[16]}}, pos_y_i, 12'b0});
    dx = y_q >>> i_q;
    dy = x_q >>> i_q;
    busy_d = busy_q;
    done_d = 1'b0;
    x_d = x_q;
    y_d = y_q;
    z_d = z_q;
    i_d = i_q;
    if (start_i) begin
      busy_d = 1'b1;
      i_d    = '0;
      if (xs[W-1]) begin
        x_d = -xs;
        y_d = -ys;
        z_d = 32'h80000000;
      end else begin
        x_d = xs;
        y_d = ys;
        z_d = '0;
      end
    end else if (busy_q) begin
      // rotate towards the x axis, one micro-rotation a cycle
      if (!y_q[W-1]) begin
        x_d = x_q + dx;
        y_d = y_q - dy;
        z_d = z_q + hsch_pkg::atan_turns(i_q);
      end else begin
        x_d = x_q - dx;
        y_d = y_q + dy;
        z_d = z_q - hsch_pkg::atan_turns(i_q);
      end
      i_d = i_q + 1'b1;
      if (i_q == hsch_pkg::StepW'(CORDIC_STEPS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      i_q    <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      i_q    <= i_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
    z_q <= z_d;
  end

  assign done_o  = done_q;
  assign angle_o = z_q;

endmodule

@@ sv/hsch_hist.sv @@
module hsch_hist #(
  parameter int NUM_BINS = hsch_pkg::NumBinsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  hsch_pkg::hist_req_t req_i,
  output hsch_pkg::hist_rsp_t rsp_o
);

  localparam int IW = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
  localparam int CD = 3 * NUM_BINS;
  localparam int CW = $clog2(CD);
  localparam int BX = (hsch_pkg::BinW > 13) ? hsch_pkg::BinW : 13;

  logic [hsch_pkg::SumW-1:0] all_mem [NUM_BINS];
  logic [hsch_pkg::SumW-1:0] cls_mem [CD];

  hsch_pkg::hist_state_e state_q, state_d;
  logic [CW:0]  clr_q, clr_d;
  logic [1:0]   k_q, k_d;
  logic         rd_q, rd_d, oor_q, oor_d, done_q, done_d;
  logic [IW-1:0] bin_q, bin_d;
  logic [31:0]  w_q, w_d;
  logic [hsch_pkg::SumW-1:0] all_rd_q, cls_rd_q;
  logic [hsch_pkg::SumW-1:0] s_all_q, s_all_d, s_c_q, s_c_d, s_t_q, s_t_d, s_o_q, s_o_d;
  logic [CW-1:0] cls_addr;
  logic [CW:0]   cls_addr_w;
  logic          clr_all, clr_cls, wr_all, wr_cls;
  logic [hsch_pkg::SumW-1:0] all_wdata, cls_wdata;

  always_comb begin
    cls_addr_w = (CW + 1)'(k_q) * (CW + 1)'(NUM_BINS) + (CW + 1)'(bin_q);
    cls_addr   = cls_addr_w[CW-1:0];
  end

  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    k_d     = k_q;
    rd_d    = rd_q;
    oor_d   = oor_q;
    bin_d   = bin_q;
    w_d     = w_q;
    done_d  = 1'b0;
    s_all_d = s_all_q;
    s_c_d   = s_c_q;
    s_t_d   = s_t_q;
    s_o_d   = s_o_q;
    clr_all = 1'b0;
    clr_cls = 1'b0;
    wr_all  = 1'b0;
    wr_cls  = 1'b0;
    all_wdata = all_rd_q + {32'b0, w_q};
    cls_wdata = cls_rd_q + {32'b0, w_q};
    unique case (state_q)
      hsch_pkg::HS_CLEAR: begin
        clr_cls = 1'b1;
        clr_all = (clr_q < (CW + 1)'(NUM_BINS));
        clr_d   = clr_q + 1'b1;
        if (clr_q == (CW + 1)'(CD - 1)) state_d = hsch_pkg::HS_IDLE;
      end
      hsch_pkg::HS_IDLE: begin
        if (req_i.start) begin
          rd_d  = req_i.rd;
          w_d   = req_i.weight;
          oor_d = BX'(req_i.bin) >= BX'(NUM_BINS);
          bin_d = oor_d ? '0 : IW'(req_i.bin);
          k_d   = req_i.rd ? 2'd0 : req_i.cls;
          s_all_d = '0;
          s_c_d   = '0;
          s_t_d   = '0;
          s_o_d   = '0;
          state_d = hsch_pkg::HS_RD;
        end
      end
      hsch_pkg::HS_RD: state_d = hsch_pkg::HS_CAP;
      hsch_pkg::HS_CAP: begin
        if (rd_q) begin
          if (!oor_q) begin
            if (k_q == 2'd0) s_all_d = all_rd_q;
            case (k_q)
              2'd0:    s_c_d = cls_rd_q;
              2'd1:    s_t_d = cls_rd_q;
              default: s_o_d = cls_rd_q;
            endcase
          end
          if (k_q == 2'd2) begin
            done_d  = 1'b1;
            state_d = hsch_pkg::HS_IDLE;
          end else begin
            k_d     = k_q + 1'b1;
            state_d = hsch_pkg::HS_RD;
          end
        end else begin
          // add the weight to the shared bin and to the class bin
          wr_all  = 1'b1;
          wr_cls  = 1'b1;
          done_d  = 1'b1;
          state_d = hsch_pkg::HS_IDLE;
        end
      end
      default: state_d = hsch_pkg::HS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= hsch_pkg::HS_CLEAR;
      clr_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q   <= k_d;
    rd_q  <= rd_d;
    oor_q <= oor_d;
    bin_q <= bin_d;
    w_q   <= w_d;
    s_all_q <= s_all_d;
    s_c_q   <= s_c_d;
    s_t_q   <= s_t_d;
    s_o_q   <= s_o_d;
  end

  always_ff @(posedge clk_i) begin
    if (clr_all) all_mem[clr_q[IW-1:0]] <= '0;
    else if (wr_all) all_mem[bin_q] <= all_wdata;
    all_rd_q <= all_mem[bin_q];
  end

  always_ff @(posedge clk_i) begin
    if (clr_cls) cls_mem[clr_q[CW-1:0]] <= '0;
    else if (wr_cls) cls_mem[cls_addr] <= cls_wdata;
    cls_rd_q <= cls_mem[cls_addr];
  end

  assign rsp_o.ready      = (state_q == hsch_pkg::HS_IDLE);
  assign rsp_o.done       = done_q;
  assign rsp_o.sum_all    = s_all_q;
  assign rsp_o.sum_closed = s_c_q;
  assign rsp_o.sum_trans  = s_t_q;
  assign rsp_o.sum_open   = s_o_q;

endmodule
